>>> rtl/core/yuv_rgb_to_masked_pixel_assert.svh
// Assertion macros for the masked pixel converter checkers.
`ifndef YUV_RGB_TO_MASKED_PIXEL_ASSERT_SVH
`define YUV_RGB_TO_MASKED_PIXEL_ASSERT_SVH

// Clocked assertion, off while reset is asserted.
`define YRM_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define YRM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/yrm_pkg.sv
// Package: codes, channel placement type and pixel math helpers.
`timescale 1ns / 1ps

package yrm_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_W        = 24;
    localparam int OUT_W       = 32;

    // Register indexes of the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SOURCE_FORMAT  = 3'd0,
        REG_CHROMA_PRESENT = 3'd1,
        REG_RED_MASK       = 3'd2,
        REG_GREEN_MASK     = 3'd3,
        REG_BLUE_MASK      = 3'd4
    } cfg_reg_t;

    // Source formats; the unused code behaves as YUV
    typedef enum logic [1:0] {
        FMT_RGB24 = 2'd0,
        FMT_BGR24 = 2'd1,
        FMT_YUV   = 2'd2
    } fmt_t;

    // BT.601 factors, 18-bit signed fixed point with 16 fraction bits
    localparam logic signed [17:0] K_RV = 18'sd91881;
    localparam logic signed [17:0] K_GU = 18'sd22554;
    localparam logic signed [17:0] K_GV = 18'sd46802;
    localparam logic signed [17:0] K_BU = 18'sd116130;
    localparam logic [8:0]         CHROMA_BIAS = 9'd128;

    // Placement of one channel: enable, lowest mask bit, right shift of the byte
    typedef struct packed {
        logic       en;
        logic [4:0] lsb;
        logic [2:0] rsh;
    } chan_t;

    // Reduce a channel mask to its lowest run of set bits
    function automatic chan_t decode_mask(input logic [31:0] mask);
        chan_t      ch;
        logic [31:0] run;
        logic [3:0] bits;
        logic       stop;
        ch.en  = |mask;
        ch.lsb = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (mask[i])
            begin
                ch.lsb = 5'(i);
            end
        end
        run  = mask >> ch.lsb;
        bits = '0;
        stop = 1'b0;
        for (int j = 0; j < 8; j++)
        begin
            if (!stop && run[j])
            begin
                bits = bits + 4'd1;
            end
            else
            begin
                stop = 1'b1;
            end
        end
        ch.rsh = 3'(4'd8 - bits);
        return ch;
    endfunction

    localparam chan_t RED_RESET   = decode_mask(32'h00FF_0000);
    localparam chan_t GREEN_RESET = decode_mask(32'h0000_FF00);
    localparam chan_t BLUE_RESET  = decode_mask(32'h0000_00FF);

    // Clamp a signed sum to a byte
    function automatic logic [7:0] sat_byte(input logic signed [10:0] s);
        logic [7:0] r;
        if (s[10])
        begin
            r = 8'd0;
        end
        else if (s[9:8] != 2'b00)
        begin
            r = 8'd255;
        end
        else
        begin
            r = s[7:0];
        end
        return r;
    endfunction

    // Place a byte under its channel mask
    function automatic logic [31:0] place_channel(input chan_t ch, input logic [7:0] val);
        logic [31:0] r;
        if (!ch.en)
        begin
            r = '0;
        end
        else
        begin
            r = {24'd0, val >> ch.rsh} << ch.lsb;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/yuv_rgb_to_masked_pixel.sv
// Top level: pixel format conversion and mask packing, one item per clock while m_tready is high.
`timescale 1ns / 1ps

// Channel   Signals                     Payload
// s_*       s_tvalid s_tready s_tdata   component_first/second/third
// m_*       m_tvalid m_tready m_tdata   packed_pixel
// cfg_*     cfg_we cfg_index cfg_data   five configuration registers
//
// Items pass through the input register, then conversion and packing into the
// result register. One item is accepted every clock while m_tready is high.
// A stalled result holds; the input register still takes one more item if empty.
// Reset clears both valid flags and loads the register defaults; there is no
// clearing pass. Mask writes are decoded into shift and width at the write.
module yuv_rgb_to_masked_pixel
    import yrm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [7:0] component_first, [15:8] component_second, [23:16] component_third
    input  logic [IN_W-1:0]        s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [31:0] packed_pixel
    output logic [OUT_W-1:0]       m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [1:0]  source_format_reg;
    logic        chroma_present_reg;
    chan_t       red_reg;
    chan_t       green_reg;
    chan_t       blue_reg;

    logic        s1_valid_reg;
    logic [7:0]  c0_reg;
    logic [7:0]  c1_reg;
    logic [7:0]  c2_reg;
    logic        m_valid_reg;
    logic [31:0] m_data_reg;

    logic        adv_out;
    logic        adv_in;

    logic signed [8:0]  u_s;
    logic signed [8:0]  v_s;
    logic signed [26:0] prod_r;
    logic signed [26:0] prod_g;
    logic signed [26:0] prod_b;
    logic signed [10:0] sum_r;
    logic signed [10:0] sum_g;
    logic signed [10:0] sum_b;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [31:0] m_data_next;

    // Write configuration; masks are stored as decoded placements
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_format_reg  <= FMT_YUV;
            chroma_present_reg <= 1'b1;
            red_reg            <= RED_RESET;
            green_reg          <= GREEN_RESET;
            blue_reg           <= BLUE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SOURCE_FORMAT:  source_format_reg  <= cfg_data[1:0];
                REG_CHROMA_PRESENT: chroma_present_reg <= cfg_data[0];
                REG_RED_MASK:       red_reg            <= decode_mask(cfg_data);
                REG_GREEN_MASK:     green_reg          <= decode_mask(cfg_data);
                REG_BLUE_MASK:      blue_reg           <= decode_mask(cfg_data);
                default:            ;
            endcase
        end
    end

    // Advance the two stages when the stage ahead is free or draining
    assign adv_out  = !m_valid_reg || m_tready;
    assign adv_in   = !s1_valid_reg || adv_out;
    assign s_tready = adv_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (adv_in)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (adv_out)
            begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Hold input payload
    always_ff @(posedge clk)
    begin
        if (adv_in && s_tvalid)
        begin
            c0_reg <= s_tdata[7:0];
            c1_reg <= s_tdata[15:8];
            c2_reg <= s_tdata[23:16];
        end
    end

    // Chroma offsets and fixed-point products
    always_comb
    begin
        if (chroma_present_reg)
        begin
            u_s = $signed({1'b0, c1_reg} - CHROMA_BIAS);
            v_s = $signed({1'b0, c2_reg} - CHROMA_BIAS);
        end
        else
        begin
            u_s = '0;
            v_s = '0;
        end
        prod_r = K_RV * v_s;
        prod_g = K_GU * u_s + K_GV * v_s;
        prod_b = K_BU * u_s;
        // floor shift by 16 is the upper bits of the product
        sum_r  = $signed({3'b000, c0_reg}) + $signed(prod_r[26:16]);
        sum_g  = $signed({3'b000, c0_reg}) - $signed(prod_g[26:16]);
        sum_b  = $signed({3'b000, c0_reg}) + $signed(prod_b[26:16]);
    end

    // Select components by source format
    always_comb
    begin
        case (source_format_reg)
            FMT_RGB24:
            begin
                red   = c0_reg;
                green = c1_reg;
                blue  = c2_reg;
            end
            FMT_BGR24:
            begin
                red   = c2_reg;
                green = c1_reg;
                blue  = c0_reg;
            end
            default:
            begin
                red   = sat_byte(sum_r);
                green = sat_byte(sum_g);
                blue  = sat_byte(sum_b);
            end
        endcase
        m_data_next = place_channel(red_reg, red)
                    | place_channel(green_reg, green)
                    | place_channel(blue_reg, blue);
    end

    // Hold result payload
    always_ff @(posedge clk)
    begin
        if (adv_out && s1_valid_reg)
        begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> rtl/core/yrm_checker.sv
// Port checker for the masked pixel converter, bound to the top level.
`timescale 1ns / 1ps
`include "yuv_rgb_to_masked_pixel_assert.svh"

module yrm_checker
    import yrm_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_W-1:0]       m_tdata
);

    logic out_stall;
    logic in_acc;

    assign out_stall = m_tvalid && !m_tready;
    assign in_acc    = s_tvalid && s_tready;

    // Result channel stays valid and holds its item while stalled
    `YRM_ASSERT_CLK(a_out_hold_valid, clk, rst_n, out_stall |=> m_tvalid, "result dropped")
    `YRM_ASSERT_CLK(a_out_hold_data, clk, rst_n, out_stall |=> $stable(m_tdata), "result changed")

    // A new result rises only for a taken item, via the input and result registers
    `YRM_ASSERT_CLK(a_out_src, clk, rst_n, $rose(m_tvalid) |-> $past(in_acc, 2), "stray result")

    // With the result side empty, the input side takes an item
    `YRM_ASSERT_CLK(a_empty_ready, clk, rst_n, !m_tvalid |-> s_tready, "input stalled")

    // No result shows during reset
    `YRM_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |-> !m_tvalid, "result valid during reset")

endmodule

bind yuv_rgb_to_masked_pixel yrm_checker u_yrm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
